// File: sv/flph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flph_pkg: shared types and constants of the four-lane Pearson string hash
// Holds the permutation ROM, the queue entry type and the lane helpers.
// ----------------------------------------------------------------------------
package flph_pkg;

    localparam int unsigned HEAD_LEN = 4;

    // Byte index codes carried with each queue entry
    localparam logic [2:0] IDX_FIRST     = 3'd0;
    localparam logic [2:0] IDX_LAST_HEAD = 3'd3;
    localparam logic [2:0] IDX_BODY      = 3'd4;

    // Catch-up sequence: slot 0 loads the lanes, slots 1..6 apply bytes 1..3
    localparam logic [2:0] SLOT_INIT = 3'd0;
    localparam logic [2:0] SLOT_LAST = 3'd6;

    localparam logic [7:0]  SLASH_BYTE = 8'h2F;
    localparam logic [7:0]  NUL_BYTE   = 8'h00;
    localparam logic [31:0] HASH_MASK  = 32'hFFFF_FFC0;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    // Four 8-bit lanes, lane 0 in the low byte
    typedef logic [HEAD_LEN-1:0][7:0] t_lanes;

    // One classified byte passed from the front end to the back end
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] idx;
        logic       mix_slash;
        logic       mix_byte;
        logic       last;
    } t_entry;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'h01, 8'h0e, 8'h6e, 8'h19, 8'h61, 8'hae, 8'h84, 8'h77,
        8'h8a, 8'haa, 8'h7d, 8'h76, 8'h1b, 8'he9, 8'h8c, 8'h33,
        8'h57, 8'hc5, 8'hb1, 8'h6b, 8'hea, 8'ha9, 8'h38, 8'h44,
        8'h1e, 8'h07, 8'had, 8'h49, 8'hbc, 8'h28, 8'h24, 8'h41,
        8'h31, 8'hd5, 8'h68, 8'hbe, 8'h39, 8'hd3, 8'h94, 8'hdf,
        8'h30, 8'h73, 8'h0f, 8'h02, 8'h43, 8'hba, 8'hd2, 8'h1c,
        8'h0c, 8'hb5, 8'h67, 8'h46, 8'h16, 8'h3a, 8'h4b, 8'h4e,
        8'hb7, 8'ha7, 8'hee, 8'h9d, 8'h7c, 8'h93, 8'hac, 8'h90,
        8'hb0, 8'ha1, 8'h8d, 8'h56, 8'h3c, 8'h42, 8'h80, 8'h53,
        8'h9c, 8'hf1, 8'h4f, 8'h2e, 8'ha8, 8'hc6, 8'h29, 8'hfe,
        8'hb2, 8'h55, 8'hfd, 8'hed, 8'hfa, 8'h9a, 8'h85, 8'h58,
        8'h23, 8'hce, 8'h5f, 8'h74, 8'hfc, 8'hc0, 8'h36, 8'hdd,
        8'h66, 8'hda, 8'hff, 8'hf0, 8'h52, 8'h6a, 8'h9e, 8'hc9,
        8'h3d, 8'h03, 8'h59, 8'h09, 8'h2a, 8'h9b, 8'h9f, 8'h5d,
        8'ha6, 8'h50, 8'h32, 8'h22, 8'haf, 8'hc3, 8'h64, 8'h63,
        8'h1a, 8'h96, 8'h10, 8'h91, 8'h04, 8'h21, 8'h08, 8'hbd,
        8'h79, 8'h40, 8'h4d, 8'h48, 8'hd0, 8'hf5, 8'h82, 8'h7a,
        8'h8f, 8'h37, 8'h69, 8'h86, 8'h1d, 8'ha4, 8'hb9, 8'hc2,
        8'hc1, 8'hef, 8'h65, 8'hf2, 8'h05, 8'hab, 8'h7e, 8'h0b,
        8'h4a, 8'h3b, 8'h89, 8'he4, 8'h6c, 8'hbf, 8'he8, 8'h8b,
        8'h06, 8'h18, 8'h51, 8'h14, 8'h7f, 8'h11, 8'h5b, 8'h5c,
        8'hfb, 8'h97, 8'he1, 8'hcf, 8'h15, 8'h62, 8'h71, 8'h70,
        8'h54, 8'he2, 8'h12, 8'hd6, 8'hc7, 8'hbb, 8'h0d, 8'h20,
        8'h5e, 8'hdc, 8'he0, 8'hd4, 8'hf7, 8'hcc, 8'hc4, 8'h2b,
        8'hf9, 8'hec, 8'h2d, 8'hf4, 8'h6f, 8'hb6, 8'h99, 8'h88,
        8'h81, 8'h5a, 8'hd9, 8'hca, 8'h13, 8'ha5, 8'he7, 8'h47,
        8'he6, 8'h8e, 8'h60, 8'he3, 8'h3e, 8'hb3, 8'hf6, 8'h72,
        8'ha2, 8'h35, 8'ha0, 8'hd7, 8'hcd, 8'hb4, 8'h2f, 8'h6d,
        8'h2c, 8'h26, 8'h1f, 8'h95, 8'h87, 8'h00, 8'hd8, 8'h34,
        8'h3f, 8'h17, 8'h25, 8'h45, 8'h27, 8'h75, 8'h92, 8'hb8,
        8'ha3, 8'hc8, 8'hde, 8'heb, 8'hf8, 8'hf3, 8'hdb, 8'h0a,
        8'h98, 8'h83, 8'h7b, 8'he5, 8'hcb, 8'h4c, 8'h78, 8'hd1
    };

    // XOR one byte into every lane and pass each lane through the ROM
    function automatic t_lanes lane_mix(input t_lanes lanes, input logic [7:0] b);
        t_lanes res;
        for (int k = 0; k < HEAD_LEN; k++) begin
            res[k] = PERM_ROM[lanes[k] ^ b];
        end
        return res;
    endfunction

    // Seed each lane from the ROM entry of its head byte
    function automatic t_lanes lane_init(input t_lanes head);
        t_lanes res;
        for (int k = 0; k < HEAD_LEN; k++) begin
            res[k] = PERM_ROM[head[k]];
        end
        return res;
    endfunction

endpackage

// File: sv/flph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flph_front: byte classifier
// Tracks the byte index, the NUL stop and the held slash of the current
// string, and tags each accepted byte with the lane mixes it calls for.
// ----------------------------------------------------------------------------
module flph_front
    import flph_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_entry     o_entry
);

    logic [2:0] r_idx, n_idx;
    logic       r_stopped, n_stopped;
    logic       r_slash, n_slash;
    logic       is_nul, is_slash, body;

    // Classify the incoming byte
    always_comb begin
        is_nul   = (i_data_byte == NUL_BYTE);
        is_slash = (i_data_byte == SLASH_BYTE);
        body     = (r_idx != IDX_FIRST);

        o_entry.data      = i_data_byte;
        o_entry.idx       = r_idx;
        o_entry.last      = i_final_byte;
        o_entry.mix_slash = body && !r_stopped && r_slash && !is_nul;
        o_entry.mix_byte  = body && !r_stopped && !is_nul && !is_slash;

        n_idx     = r_idx;
        n_stopped = r_stopped;
        n_slash   = r_slash;
        if (i_final_byte) begin
            n_idx     = IDX_FIRST;
            n_stopped = 1'b0;
            n_slash   = 1'b0;
        end else begin
            if (r_idx != IDX_BODY) begin
                n_idx = r_idx + 3'd1;
            end
            if (body) begin
                n_stopped = r_stopped || is_nul;
                n_slash   = !r_stopped && is_slash;
            end
        end
    end

    // Advance string state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= IDX_FIRST;
            r_stopped <= 1'b0;
            r_slash   <= 1'b0;
        end else if (i_accept) begin
            r_idx     <= n_idx;
            r_stopped <= n_stopped;
            r_slash   <= n_slash;
        end
    end

endmodule

// File: sv/flph_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flph_queue: entry queue between front and back end
// Small register queue of classified bytes with a combinational head read.
// ----------------------------------------------------------------------------
module flph_queue
    import flph_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_entry,
    input  logic   i_rd,
    output t_entry o_rd_entry,
    output logic   o_full,
    output logic   o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr, do_rd;

    assign o_full     = (r_count == CNT_FULL);
    assign o_empty    = (r_count == '0);
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: sv/flph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flph_back: lane engine
// Runs one ROM level per lane per cycle: buffers the head bytes, performs
// the catch-up sequence at byte three, mixes later bytes and emits results.
// ----------------------------------------------------------------------------
module flph_back
    import flph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_hash_word,
    output logic        o_status
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_CATCH = 3'b010,
        ST_BYTE  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_slot, n_slot;
    t_lanes           r_lanes, n_lanes;
    t_lanes           r_head, n_head;
    logic [HEAD_LEN-1:0] r_hms, n_hms, r_hmb, n_hmb;
    logic             r_out_valid;
    logic [31:0]      r_hash;
    logic             r_status;
    logic             out_free, emit, emit_short;
    logic [1:0]       slot_k;

    assign out_free = !r_out_valid || i_pop;
    assign slot_k   = r_slot[2:1] + {1'b0, r_slot[0]};

    // Sequence the lane work for the entry at the queue head
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_lanes    = r_lanes;
        n_head     = r_head;
        n_hms      = r_hms;
        n_hmb      = r_hmb;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        emit_short = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (!i_q_empty) begin
                    if (i_entry.idx < IDX_LAST_HEAD) begin
                        if (!i_entry.last || out_free) begin
                            n_head[i_entry.idx[1:0]] = i_entry.data;
                            n_hms[i_entry.idx[1:0]]  = i_entry.mix_slash;
                            n_hmb[i_entry.idx[1:0]]  = i_entry.mix_byte;
                            o_q_pop    = 1'b1;
                            emit       = i_entry.last;
                            emit_short = 1'b1;
                        end
                    end else if (i_entry.idx == IDX_LAST_HEAD) begin
                        n_head[HEAD_LEN-1] = i_entry.data;
                        n_hms[HEAD_LEN-1]  = i_entry.mix_slash;
                        n_hmb[HEAD_LEN-1]  = i_entry.mix_byte;
                        n_slot  = SLOT_INIT;
                        n_state = ST_CATCH;
                    end else if (i_entry.mix_slash && i_entry.mix_byte) begin
                        n_lanes = lane_mix(r_lanes, SLASH_BYTE);
                        n_state = ST_BYTE;
                    end else if (!i_entry.last || out_free) begin
                        if (i_entry.mix_slash) begin
                            n_lanes = lane_mix(r_lanes, SLASH_BYTE);
                        end else if (i_entry.mix_byte) begin
                            n_lanes = lane_mix(r_lanes, i_entry.data);
                        end
                        o_q_pop = 1'b1;
                        emit    = i_entry.last;
                    end
                end
            end
            ST_CATCH: begin
                if (r_slot == SLOT_INIT) begin
                    n_lanes = lane_init(r_head);
                    n_slot  = r_slot + 3'd1;
                end else if (r_slot != SLOT_LAST || !i_entry.last || out_free) begin
                    // odd slots apply a held slash, even slots the byte itself
                    if (r_slot[0] && r_hms[slot_k]) begin
                        n_lanes = lane_mix(r_lanes, SLASH_BYTE);
                    end else if (!r_slot[0] && r_hmb[slot_k]) begin
                        n_lanes = lane_mix(r_lanes, r_head[slot_k]);
                    end
                    if (r_slot == SLOT_LAST) begin
                        o_q_pop = 1'b1;
                        emit    = i_entry.last;
                        n_state = ST_RUN;
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                end
            end
            ST_BYTE: begin
                if (!i_entry.last || out_free) begin
                    n_lanes = lane_mix(r_lanes, i_entry.data);
                    o_q_pop = 1'b1;
                    emit    = i_entry.last;
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Hold sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_slot  <= SLOT_INIT;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // Update lanes and buffered head bytes
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_head  <= n_head;
        r_hms   <= n_hms;
        r_hmb   <= n_hmb;
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hash   <= emit_short ? '0 : (32'(n_lanes) & HASH_MASK);
            r_status <= emit_short ? STATUS_SHORT : STATUS_OK;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_hash_word = r_hash;
    assign o_status    = r_status;

endmodule

// File: sv/four_lane_pearson_string_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_pearson_string_hash_top: four-lane Pearson string hash
// Hashes a byte string into a 32-bit word with four ROM-driven lanes.
// ----------------------------------------------------------------------------
// The block takes one string byte per cycle through push/full and returns
// one result per string (on the byte flagged final) through empty/pop. The
// front end classifies each byte in the cycle it is taken and writes it to
// a QUEUE_DEPTH-entry queue; the back end performs one ROM level on all four
// lanes per cycle, holding a final byte while an earlier result still waits.
// An ordinary byte takes one ROM level, a slash that is followed by a hashed
// byte is mixed as the slash and then the byte, and the fourth byte of every
// string is captured, then seeds the lanes, then applies the deferred mixes
// of bytes one to three. The queue absorbs these bursts, so push stalls only
// when it fills. A result passes through the queue and the back end into the
// output register, where it waits; new input is still taken until the queue
// fills.
// ----------------------------------------------------------------------------
module four_lane_pearson_string_hash_top
    import flph_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_word,
    output logic        o_status
);

    t_entry front_entry, head_entry;
    logic   accept, q_empty, q_pop;

    assign accept = push && !full;

    flph_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_entry      (front_entry)
    );

    flph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (accept),
        .i_wr_entry (front_entry),
        .i_rd       (q_pop),
        .o_rd_entry (head_entry),
        .o_full     (full),
        .o_empty    (q_empty)
    );

    flph_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hash_word (o_hash_word),
        .o_status    (o_status)
    );

endmodule

// File: sv/flph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flph_checker: port-level checks for the Pearson string hash
// Watches the top-level ports for result encoding and reset behaviour.
// ----------------------------------------------------------------------------
module flph_checker
    import flph_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_hash_word,
    input logic        o_status
);

    // Short strings carry a zero hash
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STATUS_SHORT) |-> (o_hash_word == '0))
        else $error("short-string result with non-zero hash");

    // Low six bits of every result are cleared
    a_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_hash_word[5:0] == 6'd0))
        else $error("hash low bits not cleared");

    // Reset drains both sides
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not idle after reset");

    // A waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hash_word) && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind four_lane_pearson_string_hash_top flph_checker u_flph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_hash_word (o_hash_word),
    .o_status    (o_status)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-lane Pearson string hash
// Streams strings into the hash block through its input queue with random
// gaps, and pops results with random stalls. Each popped result is compared
// with a local model of the lane hashing: NUL stop, held slash, slash at end
// and short strings. A few directed strings come first, then random ones.
// ----------------------------------------------------------------------------
module tb_top;
    import flph_pkg::*;

    localparam int unsigned BYTE_TARGET = 850;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned DIR_ROWS = 23;

    typedef struct packed {
        logic [31:0] hash;
        logic        status;
    } t_digest;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        logic [31:0] hash;
        logic        status;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_final_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_hash_word;
    logic        o_status;

    // Side information travelling with each pushed byte
    logic        row_typed = 1'b0;
    logic [31:0] row_hash = '0;
    logic        row_status = STATUS_OK;

    // Model state of the hash
    logic [7:0]  mdl_lanes [HEAD_LEN];
    logic [7:0]  mdl_head [HEAD_LEN];
    logic [2:0]  mdl_count;
    logic        mdl_stopped;
    logic        mdl_slash;

    t_digest     digest_q [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    t_dir_row    dir_rows [DIR_ROWS];

    four_lane_pearson_string_hash_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .empty        (empty),
        .pop          (pop),
        .o_hash_word  (o_hash_word),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clear the model to its post-reset state
    task automatic clear_model();
        for (int k = 0; k < HEAD_LEN; k++) begin
            mdl_lanes[k] = 8'h00;
            mdl_head[k]  = 8'h00;
        end
        mdl_count   = IDX_FIRST;
        mdl_stopped = 1'b0;
        mdl_slash   = 1'b0;
    endtask

    // One ROM round on every lane with byte b folded in
    task automatic stir_lanes(input logic [7:0] b);
        for (int k = 0; k < HEAD_LEN; k++) begin
            mdl_lanes[k] = PERM_ROM[mdl_lanes[k] ^ b];
        end
    endtask

    // Apply a byte at index one or later: NUL stop and held slash
    task automatic fold_byte(input logic [7:0] b);
        if (mdl_stopped) begin
            return;
        end
        if (mdl_slash) begin
            mdl_slash = 1'b0;
            if (b == NUL_BYTE) begin
                mdl_stopped = 1'b1;
                return;
            end
            stir_lanes(SLASH_BYTE);
        end
        if (b == NUL_BYTE) begin
            mdl_stopped = 1'b1;
        end else if (b == SLASH_BYTE) begin
            mdl_slash = 1'b1;
        end else begin
            stir_lanes(b);
        end
    endtask

    // Advance the model by one byte; produce the digest on the final byte
    task automatic hash_byte(input logic [7:0] b, input logic fin,
                             output bit produced, output t_digest d);
        logic [2:0] idx;
        idx = mdl_count;
        produced = 1'b0;
        d = '0;
        if (idx < IDX_LAST_HEAD) begin
            mdl_head[idx] = b;
            mdl_count = idx + 3'd1;
        end else if (idx == IDX_LAST_HEAD) begin
            mdl_head[idx] = b;
            for (int k = 0; k < HEAD_LEN; k++) begin
                mdl_lanes[k] = PERM_ROM[mdl_head[k]];
            end
            for (int k = 1; k < HEAD_LEN; k++) begin
                fold_byte(mdl_head[k]);
            end
            mdl_count = IDX_BODY;
        end else begin
            fold_byte(b);
        end
        if (fin) begin
            produced = 1'b1;
            if (idx < IDX_LAST_HEAD) begin
                d.hash   = '0;
                d.status = STATUS_SHORT;
            end else begin
                d.hash = {mdl_lanes[3], mdl_lanes[2], mdl_lanes[1], mdl_lanes[0]} & HASH_MASK;
                d.status = STATUS_OK;
            end
            clear_model();
        end
    endtask

    // Watch both handshakes: predict on push, check on pop
    always @(posedge i_clk) begin : watch
        bit      produced;
        t_digest d;
        t_digest e;
        if (i_rst_n) begin
            if (push && !full) begin
                hash_byte(i_data_byte, i_final_byte, produced, d);
                if (produced) begin
                    if (row_typed) begin
                        d.hash   = row_hash;
                        d.status = row_status;
                    end
                    digest_q.push_back(d);
                end
            end
            if (pop && !empty) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected result: hash_word %h status %b", o_hash_word, o_status);
                    mismatches++;
                end else begin
                    e = digest_q.pop_front();
                    if (o_hash_word !== e.hash) begin
                        $error("hash_word mismatch: expected %h, got %h", e.hash, o_hash_word);
                        mismatches++;
                    end
                    if (o_status !== e.status) begin
                        $error("status mismatch: expected %b, got %b", e.status, o_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drain results with random stalls, in runs of calm or busy behaviour
    initial begin : drain
        int run_left;
        int stall_max;
        int stall;
        run_left = 0;
        stall_max = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (run_left == 0) begin
                run_left  = $urandom_range(1, 20);
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            end
            run_left--;
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Offer one byte after a gap and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [31:0] th, input logic ts, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        row_typed    <= typed;
        row_hash     <= th;
        row_status   <= ts;
        do @(posedge i_clk); while (full);
    endtask

    // Pick a byte with weight on the special values
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return SLASH_BYTE;
        end else if (r < 18) begin
            return NUL_BYTE;
        end else if (r < 30) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    initial begin : stimulus
        int unsigned sent;
        int          len;
        int          gap_max;
        int unsigned r;
        logic [7:0]  b;
        logic        last;

        // Directed strings: short ones, all-zero head, extremes, slash and NUL rules
        dir_rows = '{
            '{8'h00, 1'b1, 1'b1, 32'h0000_0000, STATUS_SHORT},
            '{8'hFF, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'hFF, 1'b1, 1'b1, 32'h0000_0000, STATUS_SHORT},
            '{8'h01, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h02, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h03, 1'b1, 1'b1, 32'h0000_0000, STATUS_SHORT},
            '{8'h00, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h00, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h00, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h00, 1'b1, 1'b1, 32'h0101_0100, STATUS_OK},
            '{8'hFF, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h2F, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h00, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'hFF, 1'b1, 1'b0, 32'h0, STATUS_OK},
            '{8'h2F, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h2F, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h61, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h80, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h2F, 1'b1, 1'b0, 32'h0, STATUS_OK},
            '{8'h7F, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h01, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h00, 1'b0, 1'b0, 32'h0, STATUS_OK},
            '{8'h55, 1'b1, 1'b0, 32'h0, STATUS_OK}
        };

        clear_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].hash, dir_rows[i].status, $urandom_range(0, 3));
        end

        // Random strings, mostly of ordinary length, some short, a few long
        sent = 0;
        while (sent < BYTE_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = $urandom_range(1, 3);
            end else if (r < 88) begin
                len = $urandom_range(4, 12);
            end else begin
                len = $urandom_range(13, 40);
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            for (int i = 0; i < len; i++) begin
                last = (i == len - 1);
                b = pick_byte();
                if (last && $urandom_range(0, 9) == 0) begin
                    b = SLASH_BYTE;
                end
                send_byte(b, last, 1'b0, '0, STATUS_OK, $urandom_range(0, gap_max));
                sent++;
            end
        end
        push <= 1'b0;

        // Wait for outstanding results, then let the pipeline settle
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
